@@ design/ptpd_pkg.sv @@
// Package with payload types and constants for the perspective-divide point transform.
`timescale 1ns / 1ps
package ptpd_pkg;

	localparam int NUM_REGS  = 8;
	localparam int CFG_IDX_W = 8;
	localparam int ACC_W     = 49;   // rounded column value, signed
	localparam int MAG_W     = 49;   // magnitude of a column value
	localparam int REM_W     = 50;   // divider partial remainder
	localparam int Q_W       = 32;   // quotient bits kept before saturation

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} point_in_t;

	typedef struct packed {
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic signed [31:0] qz;
		logic               w_zero;
	} point_out_t;

	// State of one quotient lane as it walks down the divider stages.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [Q_W-1:0]   quot;
		logic [31:0]      nlow;
		logic             ovf;
		logic             neg;
	} div_lane_t;

endpackage

@@ design/point_transform_perspective_divide.sv @@
// Top level: 4x4 homogeneous point transform followed by a pipelined perspective divide.
// Points move through the stages multiply, column sum, sign prep, then 32 one-bit
// stages of a restoring divider per coordinate, then saturation into the output register.
// Throughput is one point per cycle while out_stall does not back the pipeline up.
// Empty stages keep filling while the output is stalled, so bubbles are squeezed out.
// arst_n clears all valid bits and loads the identity matrix into the registers.
`timescale 1ns / 1ps
module point_transform_perspective_divide (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ptpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [63:0]                       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  ptpd_pkg::point_in_t               in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output ptpd_pkg::point_out_t              out_data
);
	import ptpd_pkg::*;

	localparam int NDIV = Q_W;

	logic [63:0] cfg_q [NUM_REGS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= 64'h0000_0000_0001_0000;
			cfg_q[1] <= 64'h0;
			cfg_q[2] <= 64'h0001_0000_0000_0000;
			cfg_q[3] <= 64'h0;
			cfg_q[4] <= 64'h0;
			cfg_q[5] <= 64'h0000_0000_0001_0000;
			cfg_q[6] <= 64'h0;
			cfg_q[7] <= 64'h0001_0000_0000_0000;
		end else if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// Matrix element of row r, column c.
	logic signed [31:0] m [4][4];
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				m[r][c] = (c % 2 == 0) ? cfg_q[r*2 + c/2][31:0] : cfg_q[r*2 + c/2][63:32];
			end
		end
	end

	// Stall chain: a stage may load when it is empty or the next one loads.
	logic en_out, en_s3, en_s2, en_s1;
	logic en_dv [NDIV];
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic v_dv [NDIV];

	assign en_out = !out_valid_q || !out_stall;
	always_comb begin
		en_dv[NDIV-1] = !v_dv[NDIV-1] || en_out;
		for (int k = NDIV-2; k >= 0; k--) begin
			en_dv[k] = !v_dv[k] || en_dv[k+1];
		end
	end
	assign en_s3    = !v_s3 || en_dv[0];
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	// Stage 1: twelve products and the translation row.
	logic signed [63:0] prod_s1 [4][3];
	logic signed [31:0] tr_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en_s1) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[c][0] <= in_data.px * m[0][c];
				prod_s1[c][1] <= in_data.py * m[1][c];
				prod_s1[c][2] <= in_data.pz * m[2][c];
				tr_s1[c]      <= m[3][c];
			end
		end
	end

	// Stage 2: exact column sum, rounded to nearest Q16.16 with ties up.
	logic signed [ACC_W-1:0] acc_s2 [4];
	logic signed [66:0]      csum [4];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			csum[c] = 67'(prod_s1[c][0]) + 67'(prod_s1[c][1]) + 67'(prod_s1[c][2])
				+ (67'(tr_s1[c]) <<< 16) + 67'sd32768;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en_s2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int c = 0; c < 4; c++) acc_s2[c] <= csum[c][64:16];
		end
	end

	// Stage 3: magnitudes, signs, overflow detection and divider seed.
	logic [MAG_W-1:0] wmag;
	logic [MAG_W-1:0] nmag [3];
	div_lane_t        seed [3];
	div_lane_t        lane_s3 [3];
	logic [MAG_W-1:0] dm_s3;
	logic             wz_s3;

	always_comb begin
		wmag = acc_s2[3][ACC_W-1] ? MAG_W'(-acc_s2[3]) : MAG_W'(acc_s2[3]);
		for (int c = 0; c < 3; c++) begin
			nmag[c] = acc_s2[c][ACC_W-1] ? MAG_W'(-acc_s2[c]) : MAG_W'(acc_s2[c]);
			seed[c].rem  = REM_W'(nmag[c] >> 16);
			seed[c].quot = '0;
			seed[c].nlow = {nmag[c][15:0], 16'h0};
			// The quotient reaches 2^32 exactly when nm >= dm * 2^16.
			seed[c].ovf  = {16'h0, nmag[c]} >= {wmag, 16'h0};
			seed[c].neg  = acc_s2[c][ACC_W-1] ^ acc_s2[3][ACC_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en_s3) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			lane_s3 <= seed;
			dm_s3   <= wmag;
			wz_s3   <= (acc_s2[3] == '0);
		end
	end

	// Divider stages: one restoring step per stage for each of the three lanes.
	div_lane_t        lane_dv [NDIV][3];
	logic [MAG_W-1:0] dm_dv [NDIV];
	logic             wz_dv [NDIV];

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		div_lane_t        src [3];
		div_lane_t        nxt [3];
		logic [MAG_W-1:0] dm_src;
		logic             wz_src;
		logic             v_src;
		logic [REM_W-1:0] shr [3];

		if (k == 0) begin : g_first
			assign src    = lane_s3;
			assign dm_src = dm_s3;
			assign wz_src = wz_s3;
			assign v_src  = v_s3;
		end else begin : g_rest
			assign src    = lane_dv[k-1];
			assign dm_src = dm_dv[k-1];
			assign wz_src = wz_dv[k-1];
			assign v_src  = v_dv[k-1];
		end

		always_comb begin
			for (int c = 0; c < 3; c++) begin
				shr[c] = {src[c].rem[REM_W-2:0], src[c].nlow[31]};
				nxt[c] = src[c];
				nxt[c].nlow = {src[c].nlow[30:0], 1'b0};
				if (shr[c] >= REM_W'(dm_src)) begin
					nxt[c].rem  = shr[c] - REM_W'(dm_src);
					nxt[c].quot = {src[c].quot[Q_W-2:0], 1'b1};
				end else begin
					nxt[c].rem  = shr[c];
					nxt[c].quot = {src[c].quot[Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_dv[k] <= 1'b0;
			else if (en_dv[k]) v_dv[k] <= v_src;
		end

		always_ff @(posedge clk) begin
			if (en_dv[k]) begin
				lane_dv[k] <= nxt;
				dm_dv[k]   <= dm_src;
				wz_dv[k]   <= wz_src;
			end
		end
	end

	// Output stage: sign, saturation and the zero-w override.
	logic [31:0] qres [3];
	div_lane_t   fin [3];

	assign fin = lane_dv[NDIV-1];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (wz_dv[NDIV-1]) begin
				qres[c] = '0;
			end else if (fin[c].neg) begin
				if (fin[c].ovf || fin[c].quot > 32'h8000_0000) qres[c] = 32'h8000_0000;
				else qres[c] = -fin[c].quot;
			end else begin
				if (fin[c].ovf || fin[c].quot > 32'h7FFF_FFFF) qres[c] = 32'h7FFF_FFFF;
				else qres[c] = fin[c].quot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en_out) out_valid_q <= v_dv[NDIV-1];
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_data.qx     <= qres[0];
			out_data.qy     <= qres[1];
			out_data.qz     <= qres[2];
			out_data.w_zero <= wz_dv[NDIV-1];
		end
	end

	assign out_valid = out_valid_q;

	// A flagged result carries zero coordinates.
	a_wzero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.w_zero) |-> (out_data.qx == 0 && out_data.qy == 0
			&& out_data.qz == 0))
		else $error("w_zero result with nonzero coordinates");

	// The input side only backs up when a finished result is held at the output.
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output side can move");

	// A zero divisor always sets the overflow flag in every lane.
	a_zero_w_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && wz_s3) |-> (lane_s3[0].ovf && lane_s3[1].ovf && lane_s3[2].ovf))
		else $error("zero w without overflow flag");

	// The divisor magnitude held at stage three is zero exactly when the zero-w flag is set.
	a_dm_zero_is_wz: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ((dm_s3 == 0) == wz_s3))
		else $error("divisor magnitude and zero flag disagree");

endmodule
